// File: design/vlmf_pkg.sv
// Package for the variable-length message FIFO.
// Holds the field widths, default sizes, result kind codes and the result record.
// No dependencies; every other file of the block imports it.
`default_nettype none
package vlmf_pkg;

	// Field widths of the request and result channels.
	localparam int unsigned CMD_W  = 2;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 7;
	localparam int unsigned KIND_W = 3;
	localparam int unsigned CAP_W  = 11;

	// Default sizes and the reset value of the capacity register.
	localparam int unsigned RING_BYTES_DEF = 1024;
	localparam int unsigned MAX_MSG_DEF    = 64;
	localparam int unsigned CAP_RESET      = 1024;

	// Result kinds.
	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_OK  = 3'd0,
		KIND_PUSH_REJ = 3'd1,
		KIND_POP_BYTE = 3'd2,
		KIND_POP_EMPTY = 3'd3,
		KIND_CLEARED  = 3'd4
	} kind_t;

	// One result on its way to the output stage; the byte comes from memory
	// when from_mem is set and is zero otherwise.
	typedef struct packed {
		kind_t             kind;
		logic [LEN_W-1:0]  length;
		logic              last;
		logic              from_mem;
	} result_t;

endpackage
`default_nettype wire

// File: design/vlmf_if.sv
// Request and result channel interfaces of the variable-length message FIFO.
// Each carries valid, ready and the payload; depends on vlmf_pkg.
`default_nettype none
interface vlmf_req_if
	import vlmf_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [BYTE_W-1:0] data_byte;
	logic [LEN_W-1:0]  msg_length;

	modport source (output valid, output command, output data_byte, output msg_length,
		input ready);
	modport sink (input valid, input command, input data_byte, input msg_length,
		output ready);
endinterface

interface vlmf_res_if
	import vlmf_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [BYTE_W-1:0] out_byte;
	logic [LEN_W-1:0]  out_length;
	logic              last;

	modport source (output valid, output kind, output out_byte, output out_length,
		output last, input ready);
	modport sink (input valid, input kind, input out_byte, input out_length,
		input last, output ready);
endinterface
`default_nettype wire

// File: design/vlmf_res_stage.sv
// Two-deep result stage: a skid register followed by the output register.
// Merges the popped byte from the ring memory's read register; uses vlmf_pkg and vlmf_if.
`default_nettype none
module vlmf_res_stage
	import vlmf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire result_t           in_res,
	input  wire logic [BYTE_W-1:0] mem_byte,
	output logic                   can_take,
	vlmf_res_if.source             res
);

	logic              s1_valid_s1;
	result_t           res_s1;
	logic              out_valid_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [LEN_W-1:0]  out_len_q;
	logic              out_last_q;
	logic              s1_adv;

	// The skid register moves on whenever the output register is free or being emptied.
	assign s1_adv   = !out_valid_q || res.ready;
	assign can_take = !s1_valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_adv) begin
				out_valid_q <= s1_valid_s1;
			end
			if (can_take) begin
				s1_valid_s1 <= in_valid;
			end
		end
	end

	// Payload registers. The memory read register holds until this stage moves on.
	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid_s1) begin
			out_kind_q <= res_s1.kind;
			out_byte_q <= res_s1.from_mem ? mem_byte : '0;
			out_len_q  <= res_s1.length;
			out_last_q <= res_s1.last;
		end
		if (can_take && in_valid) begin
			res_s1 <= in_res;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.kind       = out_kind_q;
	assign res.out_byte   = out_byte_q;
	assign res.out_length = out_len_q;
	assign res.last       = out_last_q;

endmodule
`default_nettype wire

// File: design/variable_length_message_fifo.sv
// A status result passes through the skid register and the output register of the result stage;
// a pop first reads the message length, then the bytes, one byte per cycle while the result stage has room.
// Push bytes and clears are taken one per cycle while no pop runs and the result stage has room;
// a pop holds the request port until its last byte is read, as the byte ring memory has a single read port.
// Reset clears pointers, counts and the capacity register (1024, or RING_BYTES if smaller);
// the ring and length memories are not cleared and need no clearing pass.
`default_nettype none
module variable_length_message_fifo
	import vlmf_pkg::*;
#(
	parameter int unsigned RING_BYTES        = RING_BYTES_DEF,
	parameter int unsigned MAX_MESSAGE_BYTES = MAX_MSG_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	vlmf_req_if.sink              req,
	vlmf_res_if.source            res,
	input  wire logic             cfg_wr_en,
	input  wire logic [CAP_W-1:0] cfg_wr_data
);

	localparam int unsigned AW      = $clog2(RING_BYTES);
	localparam int unsigned CW      = $clog2(RING_BYTES + 1);
	localparam int unsigned SW      = CW + 1;
	localparam int unsigned CAP_RST = (CAP_RESET < RING_BYTES) ? CAP_RESET : RING_BYTES;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_POP
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    eff_cap_q;
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [CW-1:0]    used_q;
	logic [AW-1:0]    head_q;
	logic [AW-1:0]    tail_q;
	logic [CW-1:0]    held_q;
	logic [LEN_W-1:0] prog_q;
	logic             drop_q;
	logic [LEN_W-1:0] pop_cnt_q;

	logic [BYTE_W-1:0] byte_mem [RING_BYTES];
	logic [LEN_W-1:0]  len_mem [RING_BYTES];
	logic [BYTE_W-1:0] byte_rd_q;
	logic [LEN_W-1:0]  len_rd_q;

	cmd_t             cmd;
	logic             slot_ok;
	logic             acc;
	logic             issue;
	logic [CW-1:0]    cap_new;
	logic [CW-1:0]    free_bytes;
	logic             run_start;
	logic             len_zero;
	logic             drop_eff;
	logic [LEN_W-1:0] seen;
	logic             is_end;
	logic [SW-1:0]    idx_sum;
	logic [AW-1:0]    wr_idx;
	logic [SW-1:0]    wp_sum;
	logic [AW-1:0]    wp_nxt;
	logic [SW-1:0]    rp_inc;
	logic [AW-1:0]    rp_nxt;
	logic [AW-1:0]    head_nxt;
	logic [AW-1:0]    tail_nxt;
	logic             pop_last;
	logic             push_skip;
	logic             byte_we;
	logic             len_we;
	logic             len_re;
	logic             res_in_valid;
	result_t          res_in;

	// Handshake: new requests only between pops, and only when the result stage has room.
	assign cmd       = cmd_t'(req.command);
	assign req.ready = (state_q == ST_IDLE) && slot_ok;
	assign acc       = req.valid && req.ready;
	assign issue     = (state_q == ST_POP) && slot_ok;

	// Clamp a written capacity to the range 1 to RING_BYTES.
	always_comb begin
		if (cfg_wr_data == '0) begin
			cap_new = CW'(1);
		end else if (32'(cfg_wr_data) > RING_BYTES) begin
			cap_new = CW'(RING_BYTES);
		end else begin
			cap_new = CW'(cfg_wr_data);
		end
	end

	// Push decision: the first byte of a run checks the message against the maximum size and the free space,
	// later bytes stop storing once the run outgrows it.
	assign free_bytes = eff_cap_q - used_q;
	assign run_start  = (prog_q == '0);
	assign len_zero   = (req.msg_length == '0);
	assign push_skip  = run_start && len_zero;

	always_comb begin
		if (run_start) begin
			drop_eff = (32'(req.msg_length) > MAX_MESSAGE_BYTES)
				|| (32'(req.msg_length) > 32'(free_bytes));
		end else begin
			drop_eff = drop_q;
		end
		if (32'(prog_q) >= 32'(free_bytes)) begin
			drop_eff = 1'b1;
		end
	end

	assign seen   = prog_q + LEN_W'(1);
	assign is_end = (seen >= req.msg_length) || (32'(seen) >= MAX_MESSAGE_BYTES);

	// Ring positions wrap at the capacity in use; the sums stay below twice that.
	assign idx_sum = SW'(wp_q) + SW'(prog_q);
	assign wr_idx  = (idx_sum >= SW'(eff_cap_q)) ? AW'(idx_sum - SW'(eff_cap_q)) : AW'(idx_sum);
	assign wp_sum  = SW'(wp_q) + SW'(seen);
	assign wp_nxt  = (wp_sum >= SW'(eff_cap_q)) ? AW'(wp_sum - SW'(eff_cap_q)) : AW'(wp_sum);
	assign rp_inc  = SW'(rp_q) + SW'(1);
	assign rp_nxt  = (rp_inc >= SW'(eff_cap_q)) ? '0 : AW'(rp_inc);

	// The length queue wraps at the full ring depth.
	assign head_nxt = (head_q == AW'(RING_BYTES - 1)) ? '0 : head_q + AW'(1);
	assign tail_nxt = (tail_q == AW'(RING_BYTES - 1)) ? '0 : tail_q + AW'(1);

	assign pop_last = ((pop_cnt_q + LEN_W'(1)) == len_rd_q);

	assign byte_we = acc && (cmd == CMD_PUSH) && !push_skip && !drop_eff;
	assign len_we  = byte_we && is_end;
	assign len_re  = acc && (cmd == CMD_POP) && (held_q != '0);

	// Ring memory: bytes go in as they arrive; a pop reads one byte per cycle while the result stage has room.
	always_ff @(posedge clk) begin
		if (byte_we) begin
			byte_mem[wr_idx] <= req.data_byte;
		end
		if (issue) begin
			byte_rd_q <= byte_mem[rp_q];
		end
	end

	// Length queue memory: written when a message commits, read when a pop starts.
	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem[tail_q] <= seen;
		end
		if (len_re) begin
			len_rd_q <= len_mem[head_q];
		end
	end

	// Result selection for the result stage.
	always_comb begin
		res_in_valid    = 1'b0;
		res_in.kind     = KIND_PUSH_OK;
		res_in.length   = '0;
		res_in.last     = 1'b1;
		res_in.from_mem = 1'b0;
		if (issue) begin
			res_in_valid    = 1'b1;
			res_in.kind     = KIND_POP_BYTE;
			res_in.length   = len_rd_q;
			res_in.last     = pop_last;
			res_in.from_mem = 1'b1;
		end else if (acc) begin
			case (cmd)
				CMD_PUSH: begin
					if (push_skip) begin
						res_in_valid = 1'b1;
					end else if (is_end) begin
						res_in_valid = 1'b1;
						res_in.kind  = drop_eff ? KIND_PUSH_REJ : KIND_PUSH_OK;
					end
				end
				CMD_POP: begin
					if (held_q == '0) begin
						res_in_valid = 1'b1;
						res_in.kind  = KIND_POP_EMPTY;
					end
				end
				CMD_CLEAR: begin
					res_in_valid = 1'b1;
					res_in.kind  = KIND_CLEARED;
				end
				default: begin
				end
			endcase
		end
	end

	// Control state: pointers, counts, the push in progress and the pop sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			eff_cap_q <= CW'(CAP_RST);
			wp_q      <= '0;
			rp_q      <= '0;
			used_q    <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			held_q    <= '0;
			prog_q    <= '0;
			drop_q    <= 1'b0;
			pop_cnt_q <= '0;
		end else if (cfg_wr_en) begin
			state_q   <= ST_IDLE;
			eff_cap_q <= cap_new;
			wp_q      <= '0;
			rp_q      <= '0;
			used_q    <= '0;
			head_q    <= '0;
			tail_q    <= '0;
			held_q    <= '0;
			prog_q    <= '0;
			drop_q    <= 1'b0;
			pop_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (cmd)
							CMD_PUSH: begin
								if (!push_skip) begin
									if (is_end) begin
										prog_q <= '0;
										drop_q <= 1'b0;
										if (!drop_eff) begin
											wp_q   <= wp_nxt;
											used_q <= used_q + CW'(seen);
											tail_q <= tail_nxt;
											held_q <= held_q + CW'(1);
										end
									end else begin
										prog_q <= seen;
										drop_q <= drop_eff;
									end
								end
							end
							CMD_POP: begin
								if (held_q != '0) begin
									pop_cnt_q <= '0;
									state_q   <= ST_POP;
								end
							end
							CMD_CLEAR: begin
								wp_q   <= '0;
								rp_q   <= '0;
								used_q <= '0;
								head_q <= '0;
								tail_q <= '0;
								held_q <= '0;
								prog_q <= '0;
								drop_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_POP: begin
					if (issue) begin
						rp_q <= rp_nxt;
						if (pop_last) begin
							pop_cnt_q <= '0;
							used_q    <= used_q - CW'(len_rd_q);
							head_q    <= head_nxt;
							held_q    <= held_q - CW'(1);
							state_q   <= ST_IDLE;
						end else begin
							pop_cnt_q <= pop_cnt_q + LEN_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	vlmf_res_stage u_res_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_in_valid),
		.in_res   (res_in),
		.mem_byte (byte_rd_q),
		.can_take (slot_ok),
		.res      (res)
	);

`ifndef SYNTHESIS
	// Committed bytes never exceed the capacity in use.
	a_used_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= eff_cap_q)
		else $error("committed byte count exceeds capacity");

	// Messages commit whole, so the ring is empty exactly when no message is held.
	a_held_used: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q == '0) == (used_q == '0))
		else $error("message count and byte count disagree");

	// A pop only runs while a committed message exists.
	a_pop_has_msg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |-> (held_q != '0))
		else $error("pop running with no message held");

	// The last byte read of a pop returns the sequencer to idle.
	a_pop_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(issue && pop_last) |=> (state_q == ST_IDLE))
		else $error("pop did not end after its last byte");
`endif

endmodule
`default_nettype wire

// File: sim/variable_length_message_fifo_tb.sv
// Self-checking testbench for the variable-length message FIFO.
// A scoreboard class keeps its own copy of the ring and the length queue and predicts every result.
// Depends on vlmf_pkg, the vlmf_req_if and vlmf_res_if interfaces and variable_length_message_fifo.
`default_nettype none
module variable_length_message_fifo_tb;
	import vlmf_pkg::*;

	// Request commands as they appear on the command field.
	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} command_t;

	localparam int unsigned RING      = RING_BYTES_DEF;
	localparam int unsigned MAX_MSG   = MAX_MSG_DEF;
	localparam int unsigned SETTLE    = 8;
	localparam int unsigned LIMIT     = 400000;
	localparam int unsigned PHASE_LEN = 20;
	localparam int unsigned IDLE_PCT  = 16;

	// Keeps a shadow of the FIFO and the results that are still owed by the block.
	class fifo_scoreboard;
		typedef struct {
			kind_t             kind;
			logic [BYTE_W-1:0] data;
			logic [LEN_W-1:0]  length;
			logic              last;
		} outcome_t;

		outcome_t          owed_q[$];
		logic [BYTE_W-1:0] byte_mem[RING];
		logic [LEN_W-1:0]  len_mem[RING];
		logic [CAP_W-1:0]  capacity;
		int unsigned       rd_ptr, wr_ptr, used, len_head, len_tail, held, progress;
		bit                dropping;
		int unsigned       errors, requests;
		int unsigned       kind_count[5];

		function new();
			capacity = CAP_W'(CAP_RESET);
			errors = 0;
			requests = 0;
			foreach (kind_count[i])
				kind_count[i] = 0;
			empty_all();
		endfunction

		function void empty_all();
			rd_ptr = 0;
			wr_ptr = 0;
			used = 0;
			len_head = 0;
			len_tail = 0;
			held = 0;
			progress = 0;
			dropping = 1'b0;
		endfunction

		// A register write also empties the buffer and abandons a push.
		function void set_capacity(logic [CAP_W-1:0] value);
			capacity = value;
			empty_all();
		endfunction

		function int unsigned usable();
			if (capacity == 0)
				return 1;
			if (capacity > RING)
				return RING;
			return capacity;
		endfunction

		function void owe(kind_t kind, logic [BYTE_W-1:0] data, logic [LEN_W-1:0] length,
			logic last);
			outcome_t o;
			o.kind = kind;
			o.data = data;
			o.length = length;
			o.last = last;
			owed_q.push_back(o);
		endfunction

		function int unsigned pending();
			return owed_q.size();
		endfunction

		// Works out the results of one accepted request.
		function void note_request(command_t cmd, logic [BYTE_W-1:0] data,
			logic [LEN_W-1:0] len);
			int unsigned lim, free_bytes, seen, idx, n, k;
			lim = usable();
			requests++;
			case (cmd)
				CMD_PUSH: begin
					free_bytes = lim - used;
					if (progress == 0) begin
						// An empty message is accepted at once and stores nothing.
						if (len == 0) begin
							owe(KIND_PUSH_OK, '0, '0, 1'b1);
							return;
						end
						dropping = (len > MAX_MSG) || (len > free_bytes);
					end
					// A length that grows mid-run can still overflow the free space.
					if (!dropping && progress >= free_bytes)
						dropping = 1'b1;
					if (!dropping) begin
						idx = wr_ptr + progress;
						if (idx >= lim)
							idx -= lim;
						byte_mem[idx] = data;
					end
					seen = progress + 1;
					if (seen < len && seen < MAX_MSG) begin
						progress = seen;
						return;
					end
					// Final byte of the run: commit or report the drop.
					if (!dropping) begin
						wr_ptr = wr_ptr + seen;
						if (wr_ptr >= lim)
							wr_ptr -= lim;
						used += seen;
						len_mem[len_tail] = LEN_W'(seen);
						len_tail = (len_tail + 1 >= RING) ? 0 : len_tail + 1;
						held++;
						owe(KIND_PUSH_OK, '0, '0, 1'b1);
					end else begin
						owe(KIND_PUSH_REJ, '0, '0, 1'b1);
					end
					progress = 0;
					dropping = 1'b0;
				end
				CMD_POP: begin
					if (held == 0) begin
						owe(KIND_POP_EMPTY, '0, '0, 1'b1);
					end else begin
						n = len_mem[len_head];
						for (k = 0; k < n; k++) begin
							owe(KIND_POP_BYTE, byte_mem[rd_ptr], LEN_W'(n), k + 1 == n);
							rd_ptr = (rd_ptr + 1 >= lim) ? 0 : rd_ptr + 1;
						end
						used -= n;
						len_head = (len_head + 1 >= RING) ? 0 : len_head + 1;
						held--;
					end
				end
				CMD_CLEAR: begin
					empty_all();
					owe(KIND_CLEARED, '0, '0, 1'b1);
				end
				default: begin
					// The unused command changes nothing.
				end
			endcase
		endfunction

		// Compares one accepted result with the oldest owed one.
		function void check_result(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
			logic [LEN_W-1:0] length, logic last);
			outcome_t want;
			if (owed_q.size() == 0) begin
				errors++;
				if (errors <= 20)
					$display("%0t: unexpected result kind %0d byte %h length %0d last %b",
						$time, kind, data, length, last);
				return;
			end
			want = owed_q.pop_front();
			if (kind !== want.kind || data !== want.data || length !== want.length ||
				last !== want.last) begin
				errors++;
				if (errors <= 20)
					$display("%0t: mismatch: expected kind %0d byte %h length %0d last %b, %s",
						$time, want.kind, want.data, want.length, want.last,
						$sformatf("got kind %0d byte %h length %0d last %b",
							kind, data, length, last));
			end
			if (want.kind <= KIND_CLEARED)
				kind_count[want.kind]++;
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [CAP_W-1:0]    cfg_wr_data = '0;
	bit                  steady = 1'b0;
	int unsigned         sent_items = 0;
	int unsigned         cfg_writes = 0;
	int unsigned         cycle_count = 0;
	fifo_scoreboard      sb = new();

	vlmf_req_if req();
	vlmf_res_if res();

	variable_length_message_fifo dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.res         (res),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// Clock with a period of four time units.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side stalls at random except during the steady stretch.
	always @(posedge clk) begin
		res.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	// Every accepted result goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			sb.check_result(res.kind, res.out_byte, res.out_length, res.last);
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, sb.pending());
			$display("TEST FAILED");
			$finish;
		end
	end

	// Offers one request, with random gaps, and holds it until it is taken.
	task automatic send_request(command_t cmd, logic [BYTE_W-1:0] data, logic [LEN_W-1:0] len);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.command <= cmd;
		req.data_byte <= data;
		req.msg_length <= len;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sb.note_request(cmd, data, len);
		if (cmd != CMD_NONE)
			sent_items++;
	endtask

	// Holds off new requests until every owed result has come, then lets the pipe settle.
	task automatic wait_drained();
		req.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_capacity(value);
		cfg_writes++;
	endtask

	// A whole message, with the odd pop slipped in between its bytes.
	task automatic push_message(int unsigned n);
		int unsigned k;
		for (k = 0; k < n; k++) begin
			if ($urandom_range(19) == 0)
				send_request(CMD_POP, BYTE_W'($urandom_range(255)),
					LEN_W'($urandom_range(127)));
			send_request(CMD_PUSH, BYTE_W'($urandom_range(255)), LEN_W'(n));
		end
	endtask

	// One random action: mostly whole messages and pops, some noise and broken runs.
	task automatic random_step();
		int unsigned pick, n, k;
		pick = $urandom_range(99);
		if (pick < 55) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(1, MAX_MSG) : $urandom_range(1, 12);
			push_message(n);
		end else if (pick < 78) begin
			send_request(CMD_POP, BYTE_W'($urandom_range(255)), LEN_W'($urandom_range(127)));
		end else if (pick < 82) begin
			send_request(CMD_CLEAR, BYTE_W'($urandom_range(255)), LEN_W'($urandom_range(127)));
		end else if (pick < 86) begin
			send_request(CMD_NONE, BYTE_W'($urandom_range(255)), LEN_W'($urandom_range(127)));
		end else if (pick < 90) begin
			send_request(CMD_PUSH, BYTE_W'($urandom_range(255)), '0);
		end else if (pick < 97) begin
			n = $urandom_range(1, 5);
			for (k = 0; k < n; k++)
				send_request(CMD_PUSH, BYTE_W'($urandom_range(255)),
					LEN_W'($urandom_range(127)));
		end else begin
			wait_drained();
		end
	endtask

	initial begin
		logic [CAP_W-1:0] cap;
		int unsigned      phase, target;
		req.valid = 1'b0;
		req.command = CMD_NONE;
		req.data_byte = '0;
		req.msg_length = '0;
		res.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty pop, extremes of data, pop during a push, zero length,
		// oversize length, length changing mid-run, clear during a push, unused command.
		send_request(CMD_POP, 8'h00, 7'd0);
		send_request(CMD_PUSH, 8'h00, 7'd1);
		send_request(CMD_PUSH, 8'hFF, 7'd3);
		send_request(CMD_POP, 8'hFF, 7'd127);
		send_request(CMD_PUSH, 8'hA5, 7'd3);
		send_request(CMD_PUSH, 8'h5A, 7'd3);
		send_request(CMD_PUSH, 8'h11, 7'd0);
		send_request(CMD_PUSH, 8'h22, 7'd127);
		send_request(CMD_PUSH, 8'h33, 7'd2);
		send_request(CMD_PUSH, 8'h44, 7'd4);
		send_request(CMD_PUSH, 8'h55, 7'd2);
		send_request(CMD_POP, 8'h00, 7'd0);
		send_request(CMD_POP, 8'h00, 7'd0);
		send_request(CMD_POP, 8'h00, 7'd0);
		send_request(CMD_PUSH, 8'h66, 7'd3);
		send_request(CMD_CLEAR, 8'h00, 7'd0);
		send_request(CMD_POP, 8'h00, 7'd0);
		send_request(CMD_NONE, 8'hFF, 7'd127);

		// Capacity of zero behaves as one byte.
		wait_drained();
		write_capacity(11'd0);
		send_request(CMD_PUSH, 8'h77, 7'd1);
		send_request(CMD_PUSH, 8'h88, 7'd1);
		send_request(CMD_POP, 8'h00, 7'd0);

		// A run whose length grows past the free space is dropped and rejected.
		wait_drained();
		write_capacity(11'd4);
		send_request(CMD_PUSH, 8'h01, 7'd3);
		repeat (4) send_request(CMD_PUSH, 8'h02, 7'd5);
		send_request(CMD_POP, 8'h00, 7'd0);

		// A register write abandons a push in progress.
		send_request(CMD_PUSH, 8'h03, 7'd3);
		wait_drained();
		write_capacity(11'h7FF);
		send_request(CMD_PUSH, 8'h04, 7'd1);
		send_request(CMD_POP, 8'h00, 7'd0);

		// Random phases, each under its own capacity; one phase runs without stalls.
		for (phase = 0; phase < 5; phase++) begin
			wait_drained();
			case (phase)
				0: cap = 11'd1024;
				1: cap = CAP_W'($urandom_range(8, 40));
				2: cap = CAP_W'($urandom_range(41, 300));
				3: cap = CAP_W'($urandom_range(1, 2047));
				default: cap = CAP_W'($urandom_range(1, 3));
			endcase
			write_capacity(cap);
			steady = (phase == 2);
			if (phase == 0)
				push_message(MAX_MSG);
			target = sent_items + PHASE_LEN;
			while (sent_items < target)
				random_step();
		end
		steady = 1'b0;

		wait_drained();
		$display("Covered %0d requests over %0d capacity settings: %0d accepted pushes,",
			sb.requests, cfg_writes, sb.kind_count[KIND_PUSH_OK]);
		$display("%0d rejected pushes, %0d popped bytes, %0d empty pops and %0d clears.",
			sb.kind_count[KIND_PUSH_REJ], sb.kind_count[KIND_POP_BYTE],
			sb.kind_count[KIND_POP_EMPTY], sb.kind_count[KIND_CLEARED]);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
`default_nettype wire
